// ===== design/iso_pkg.sv =====
`timescale 1ns / 1ps

package iso_pkg;

    // Element width and default list capacity
    localparam int VALUE_W  = 32;
    localparam int CAPACITY = 64;

    typedef logic signed [VALUE_W-1:0] t_value;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic insert;    // place the incoming element, shift larger entries up
        logic shift_dn;  // move every entry one place toward cell 0
    } t_cell_ctl;

endpackage

// ===== design/insertion_sorter.sv =====
`timescale 1ns / 1ps

// Streaming insertion sorter for signed 32-bit elements.
// Input channel: i_valid / o_stall carry one element (i_value) per transaction;
// i_is_last marks the final element of a set. Elements are accepted one per
// cycle while loading: each cell of the chain compares against the broadcast
// element, and the cells holding larger entries shift them up one place.
// Once the last element is accepted, o_stall rises and the chain drains toward
// cell 0, one result per cycle into the output register unless i_stall holds
// it. The first result shows on o_valid once the first pop loads that register;
// each stored element gives one result, and o_stall falls at the same edge that
// moves the greatest result (o_last_out = 1) into the output register.
// When the list already holds CAPACITY elements, further elements are dropped
// and o_overflow is 1 on every result of that set.
// A high i_stall holds the output transaction and pauses the drain; nothing is
// lost. Reset empties the list, clears the overflow flag and the output valid.
module insertion_sorter #(
    parameter int CAPACITY = iso_pkg::CAPACITY
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic signed [31:0]    i_value,
    input  logic                  i_is_last,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [31:0]    o_sorted_value,
    output logic                  o_last_out,
    output logic                  o_overflow
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                r_drop;
    logic                n_drop;
    logic                r_drain;
    logic                n_drain;
    logic                r_out_valid;
    logic                n_out_valid;
    iso_pkg::t_value     r_out_value;
    logic                r_out_last;
    logic                r_out_ovf;

    logic                in_xact;
    logic                full;
    logic                pop;
    iso_pkg::t_cell_ctl  ctl;

    iso_pkg::t_value     cell_data [CAPACITY];
    logic                cell_qual [CAPACITY];

    assign in_xact = i_valid && !o_stall;
    assign full    = (r_count == CNT_W'(CAPACITY));
    assign pop     = r_drain && (!r_out_valid || !i_stall);
    assign o_stall = r_drain;

    assign ctl.insert   = in_xact && !full;
    assign ctl.shift_dn = pop;

    // Build the chain of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        iso_pkg::t_value prev_data;
        logic            prev_qual;
        iso_pkg::t_value next_data;
        logic            occ;

        assign occ = (CNT_W'(g) < r_count);

        if (g == 0) begin : g_first
            assign prev_data = '0;
            assign prev_qual = 1'b0;
        end else begin : g_mid
            assign prev_data = cell_data[g-1];
            assign prev_qual = cell_qual[g-1];
        end

        if (g == CAPACITY - 1) begin : g_top
            assign next_data = '0;
        end else begin : g_below
            assign next_data = cell_data[g+1];
        end

        iso_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_value     (i_value),
            .i_occ       (occ),
            .i_prev_data (prev_data),
            .i_prev_qual (prev_qual),
            .i_next_data (next_data),
            .o_data      (cell_data[g]),
            .o_qual      (cell_qual[g])
        );
    end

    // Track fill level, overflow and drain mode
    always_comb begin
        n_count = r_count;
        n_drop  = r_drop;
        n_drain = r_drain;
        if (in_xact) begin
            if (full) begin
                n_drop = 1'b1;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
            if (i_is_last) begin
                n_drain = 1'b1;
            end
        end else if (pop) begin
            n_count = r_count - CNT_W'(1);
            if (r_count == CNT_W'(1)) begin
                n_drain = 1'b0;
                n_drop  = 1'b0;
            end
        end
    end

    // Load or release the output register
    always_comb begin
        n_out_valid = r_out_valid;
        if (pop) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_drain     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_drop      <= n_drop;
            r_drain     <= n_drain;
            r_out_valid <= n_out_valid;
        end
    end

    // Capture the smallest entry on each pop
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out_value <= cell_data[0];
            r_out_last  <= (r_count == CNT_W'(1));
            r_out_ovf   <= r_drop;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_sorted_value = r_out_value;
    assign o_last_out     = r_out_last;
    assign o_overflow     = r_out_ovf;

endmodule

// ===== design/iso_cell.sv =====
`timescale 1ns / 1ps

module iso_cell (
    input  logic                  i_clk,
    input  iso_pkg::t_cell_ctl    i_ctl,
    input  iso_pkg::t_value       i_value,
    input  logic                  i_occ,
    input  iso_pkg::t_value       i_prev_data,
    input  logic                  i_prev_qual,
    input  iso_pkg::t_value       i_next_data,
    output iso_pkg::t_value       o_data,
    output logic                  o_qual
);

    iso_pkg::t_value r_data;
    iso_pkg::t_value n_data;

    // Flag this slot as at or above the insertion point
    assign o_qual = !i_occ || (r_data > i_value);
    assign o_data = r_data;

    // Take the lower neighbor, the new element, or the upper neighbor
    always_comb begin
        n_data = r_data;
        if (i_ctl.insert) begin
            if (i_prev_qual) begin
                n_data = i_prev_data;
            end else if (o_qual) begin
                n_data = i_value;
            end
        end else if (i_ctl.shift_dn) begin
            n_data = i_next_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

// ===== tb/tb_insertion_sorter.sv =====
`timescale 1ns / 1ps

module tb_insertion_sorter;

    localparam int CAP         = iso_pkg::CAPACITY;
    localparam int RANDOM_GOAL = 250;
    localparam int DRAIN_LIMIT = 20000;
    localparam int SETTLE      = 20;

    typedef struct {
        iso_pkg::t_value value;
        bit              last;
        bit              ovf;
    } t_sorted_result;

    // DUT ports; the inputs start at known values from time zero
    logic            i_clk     = 1'b0;
    logic            i_rst_n   = 1'b0;
    logic            i_valid   = 1'b0;
    logic            o_stall;
    iso_pkg::t_value i_value   = '0;
    logic            i_is_last = 1'b0;
    logic            o_valid;
    logic            i_stall   = 1'b0;
    iso_pkg::t_value o_sorted_value;
    logic            o_last_out;
    logic            o_overflow;

    // Predicted list contents and the sorted results still owed by the block
    iso_pkg::t_value sorted_list[$];
    bit              list_dropped = 1'b0;
    t_sorted_result  sorted_due[$];

    // Idle control: quiet is shared by both sides, hold_cycles holds the output
    bit quiet       = 1'b0;
    int hold_cycles = 0;

    // Run statistics
    int error_count    = 0;
    int elements_sent  = 0;
    int sets_sent      = 0;
    int overflow_sets  = 0;
    int results_seen   = 0;
    int input_stalls   = 0;

    insertion_sorter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_value        (i_value),
        .i_is_last      (i_is_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_sorted_value (o_sorted_value),
        .o_last_out     (o_last_out),
        .o_overflow     (o_overflow)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Insert one accepted element; on the set's last element, queue the sorted run
    function automatic void insert_sorted(iso_pkg::t_value v, bit last);
        int pos;
        if (sorted_list.size() < CAP) begin
            pos = sorted_list.size();
            while (pos > 0 && sorted_list[pos-1] > v) pos--;
            sorted_list.insert(pos, v);
        end else begin
            list_dropped = 1'b1;
        end
        if (last) begin
            foreach (sorted_list[k]) begin
                t_sorted_result r;
                r.value = sorted_list[k];
                r.last  = (k == sorted_list.size() - 1);
                r.ovf   = list_dropped;
                sorted_due.push_back(r);
            end
            if (list_dropped) overflow_sets++;
            sorted_list.delete();
            list_dropped = 1'b0;
            sets_sent++;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // Offer one element and hold it until the block takes it
    task automatic send_element(input iso_pkg::t_value v, input bit last);
        int gap;
        i_valid   <= 1'b1;
        i_value   <= v;
        i_is_last <= last;
        do begin
            @(posedge i_clk);
            if (o_stall) input_stalls++;
        end while (o_stall);
        insert_sorted(v, last);
        elements_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic iso_pkg::t_value pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return iso_pkg::t_value'($urandom);
        if (r < 75) return iso_pkg::t_value'($signed($urandom_range(0, 15)) - 8);
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sh8000_0001;
            3: return 32'sh7FFF_FFFE;
            4: return -32'sd1;
            default: return 32'sd0;
        endcase
    endfunction

    task automatic send_set(input int len);
        for (int k = 0; k < len; k++) send_element(pick_value(), k == len - 1);
    endtask

    // Accept and check sorted results; pace the output stall
    initial begin
        int             r;
        int             stall_left;
        t_sorted_result exp;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                results_seen++;
                if (sorted_due.size() == 0) begin
                    $display("%0t: unexpected result value=%0d last=%0b ovf=%0b", $time,
                             o_sorted_value, o_last_out, o_overflow);
                    error_count++;
                end else begin
                    exp = sorted_due.pop_front();
                    if (o_sorted_value !== exp.value) begin
                        $display("%0t: sorted_value expected %0d actual %0d", $time,
                                 exp.value, o_sorted_value);
                        error_count++;
                    end
                    if (o_last_out !== exp.last) begin
                        $display("%0t: last_out expected %0b actual %0b", $time,
                                 exp.last, o_last_out);
                        error_count++;
                    end
                    if (o_overflow !== exp.ovf) begin
                        $display("%0t: overflow expected %0b actual %0b", $time,
                                 exp.ovf, o_overflow);
                        error_count++;
                    end
                end
            end
            // Choose the stall for the next cycle
            if (hold_cycles > 0) begin
                i_stall <= 1'b1;
                hold_cycles--;
            end else if (quiet) begin
                i_stall <= 1'b0;
                stall_left = 0;
            end else if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    i_stall <= 1'b0;
                end else begin
                    i_stall <= 1'b1;
                    stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                end
            end
        end
    end

    // Single-element set, extremes and sign boundaries
    task automatic test_extremes();
        send_element(32'sh8000_0000, 1'b1);
        send_element(32'sh7FFF_FFFF, 1'b1);
        send_element(32'sh7FFF_FFFF, 1'b0);
        send_element(32'sh8000_0000, 1'b0);
        send_element(32'sd0, 1'b0);
        send_element(-32'sd1, 1'b0);
        send_element(32'sd1, 1'b0);
        send_element(32'sh5555_5555, 1'b0);
        send_element(32'shAAAA_AAAA, 1'b1);
    endtask

    // Equal values, already ascending and fully descending input
    task automatic test_ordering();
        send_element(32'sd5, 1'b0);
        send_element(-32'sd3, 1'b0);
        send_element(32'sd5, 1'b0);
        send_element(32'sd5, 1'b0);
        send_element(-32'sd3, 1'b1);
        for (int k = 0; k < 4; k++) send_element(iso_pkg::t_value'(k * 100 - 150), k == 3);
        for (int k = 4; k > 0; k--) send_element(iso_pkg::t_value'(k * 1000 - 2500), k == 1);
    endtask

    // Exactly full list, then last element dropped, then several dropped
    task automatic test_capacity();
        send_set(CAP);
        send_set(CAP + 1);
        send_set(CAP + 6);
    endtask

    // Hold the output for a long stretch so the next set backs up at the input
    task automatic test_backpressure();
        int stalls_before;
        stalls_before = input_stalls;
        quiet = 1'b1;
        send_set(12);
        hold_cycles = 150;
        send_set(12);
        send_set(5);
        quiet = 1'b0;
        if (input_stalls == stalls_before)
            $display("%0t: note: input never stalled under output hold", $time);
    endtask

    // Random sets, mostly short, some long, a few past capacity
    task automatic test_random_sets();
        int start;
        int r;
        int len;
        start = elements_sent;
        while (elements_sent - start < RANDOM_GOAL) begin
            r = $urandom_range(0, 99);
            if (r < 70)      len = $urandom_range(1, 8);
            else if (r < 90) len = $urandom_range(9, 40);
            else if (r < 97) len = $urandom_range(41, CAP);
            else             len = $urandom_range(CAP + 1, CAP + 8);
            quiet = ($urandom_range(0, 99) < 15);
            send_set(len);
        end
        quiet = 1'b0;
    endtask

    initial begin
        int waited;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_extremes();
        test_ordering();
        test_capacity();
        test_backpressure();
        test_random_sets();
        i_valid <= 1'b0;

        // Wait for the last sorted run to drain
        waited = 0;
        while (sorted_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (sorted_due.size() != 0) begin
            $display("%0t: timed out with %0d results outstanding", $time, sorted_due.size());
            $display("Simulation FAILED");
            $finish;
        end else begin
            repeat (SETTLE) @(posedge i_clk);
            $display("Sorted %0d sets from %0d elements (%0d sets overflowed), %0d results",
                     sets_sent, elements_sent, overflow_sets, results_seen);
            $display("Input held off for %0d cycles; %0d mismatches", input_stalls,
                     error_count);
            if (error_count == 0) begin
                $display("Simulation PASSED");
            end else begin
                $display("Simulation FAILED");
            end
            $finish;
        end
    end

    // Hard stop on a hung run
    initial begin
        #5_000_000;
        $display("%0t: run limit reached", $time);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/iso_pkg.sv
design/iso_cell.sv
design/insertion_sorter.sv
tb/tb_insertion_sorter.sv
